// ===== design/cpa_pkg.sv =====
// ============================================================================
// cpa_pkg
// Shared types and constants for the coupled PI2 AQM unit: verdict codes,
// configuration register indexes, controller states and datapath operations.
// ============================================================================
package cpa_pkg;

    localparam int PROB_W    = 32;
    localparam int GAIN_W    = 18;
    localparam int K_W       = 8;
    localparam int MTU_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // magnitude (32) times gain (18)
    localparam int ACC_W     = PROB_W + GAIN_W;
    // quotient of ACC_W bits by 127 stays below 2^44
    localparam int QUO_W     = ACC_W - 6;
    localparam int TERM_W    = QUO_W + 1;
    localparam int SUM_W     = TERM_W + 2;
    localparam int CNT_W     = $clog2(ACC_W + 1);

    // 127 = 2^7 - 1, divided by folding 7-bit digits
    localparam int GAIN_SHIFT = 7;

    localparam logic [CNT_W-1:0]  DIV_STEPS    = CNT_W'(ACC_W);
    // nine folds bring a 50-bit remainder below 127
    localparam logic [CNT_W-1:0]  FOLD_STEPS   = CNT_W'(9);
    localparam logic [K_W-1:0]    GAIN_DIVISOR = K_W'(127);
    localparam logic [PROB_W-1:0] PROB_MAX     = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_K   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_OVLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MTU          = 3'd5;

    typedef enum logic [1:0] {
        VERDICT_PASS = 2'd0,
        VERDICT_MARK = 2'd1,
        VERDICT_DROP = 2'd2
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DIV1,
        ST_SAVE1,
        ST_TERM2,
        ST_DIV2,
        ST_SAVE2,
        ST_SUM,
        ST_CAP,
        ST_DIV3,
        ST_CAPSAVE,
        ST_COMMIT,
        ST_PDEC,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TERM1,
        OP_TERM2,
        OP_DIV_STEP,
        OP_FOLD,
        OP_SAVE1,
        OP_SAVE2,
        OP_SUM,
        OP_CAP_LOAD,
        OP_CAP_SAVE,
        OP_COMMIT,
        OP_PKT_MUL,
        OP_PKT_DEC
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic div_last;
        logic drop_on_overload;
    } dp_status_t;

endpackage

// ===== design/coupled_pi2_aqm_unit.sv =====
// ============================================================================
// coupled_pi2_aqm_unit
// Coupled dual-queue PI2 AQM: probability update on tick beats and
// pass/mark/drop verdicts on packet beats.
//
//   channel  ports             direction  content
//   s_       s_valid/s_ready   in         opcode, delays, packet info, rands
//   m_       m_valid/m_ready   out        verdict, probability
//   cfg_     cfg_wr_en         in         register index and write data
//
// A packet beat passes through capture, p*k multiply, decision and output
// register load. A tick beat divides each gain term by 127 in 9
// shift-and-add folds; when drop_on_overload is 0 it also caps the
// probability with a 50-step radix-2 divide by coupling_k.
// Reset is synchronous on aresetn and restores the register defaults.
// One beat is in work at a time; the result register lets the next beat be
// taken while m_ready is low, and the block stalls before emitting it.
// ============================================================================
module coupled_pi2_aqm_unit import cpa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [PROB_W-1:0]    s_delay_classic_ns,
    input  logic [PROB_W-1:0]    s_delay_l4s_ns,
    input  logic                 s_is_l4s,
    input  logic                 s_ect_capable,
    input  logic [PROB_W-1:0]    s_backlog_bytes,
    input  logic [PROB_W-1:0]    s_rand_a,
    input  logic [PROB_W-1:0]    s_rand_b,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_verdict,
    output logic [PROB_W-1:0]    m_probability
);

    dp_cmd_t    cmd;
    dp_status_t status;

    cpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .status  (status),
        .cmd     (cmd)
    );

    cpa_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_opcode           (s_opcode),
        .s_delay_classic_ns (s_delay_classic_ns),
        .s_delay_l4s_ns     (s_delay_l4s_ns),
        .s_is_l4s           (s_is_l4s),
        .s_ect_capable      (s_ect_capable),
        .s_backlog_bytes    (s_backlog_bytes),
        .s_rand_a           (s_rand_a),
        .s_rand_b           (s_rand_b),
        .m_verdict          (m_verdict),
        .m_probability      (m_probability),
        .cmd                (cmd),
        .status             (status)
    );

endmodule

// ===== design/cpa_ctrl.sv =====
// ============================================================================
// cpa_ctrl
// Sequencer for the coupled PI2 AQM unit: steps the datapath through the
// probability update or the packet decision and owns the handshakes.
// ============================================================================
module cpa_ctrl import cpa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       m_ready,
    output logic       m_valid,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '{load: 1'b0, op: OP_NONE, emit: 1'b0};
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) state_next = ST_START;
            end
            ST_START: begin
                if (status.is_tick) begin
                    cmd.op     = OP_TERM1;
                    state_next = ST_DIV1;
                end else begin
                    cmd.op     = OP_PKT_MUL;
                    state_next = ST_PDEC;
                end
            end
            ST_DIV1: begin
                cmd.op = OP_FOLD;
                if (status.div_last) state_next = ST_SAVE1;
            end
            ST_SAVE1: begin
                cmd.op     = OP_SAVE1;
                state_next = ST_TERM2;
            end
            ST_TERM2: begin
                cmd.op     = OP_TERM2;
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                cmd.op = OP_FOLD;
                if (status.div_last) state_next = ST_SAVE2;
            end
            ST_SAVE2: begin
                cmd.op     = OP_SAVE2;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.op     = OP_SUM;
                state_next = status.drop_on_overload ? ST_COMMIT : ST_CAP;
            end
            ST_CAP: begin
                cmd.op     = OP_CAP_LOAD;
                state_next = ST_DIV3;
            end
            ST_DIV3: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last) state_next = ST_CAPSAVE;
            end
            ST_CAPSAVE: begin
                cmd.op     = OP_CAP_SAVE;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.op     = OP_COMMIT;
                state_next = ST_DONE;
            end
            ST_PDEC: begin
                cmd.op     = OP_PKT_DEC;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.emit = !m_valid_reg || m_ready;
                if (cmd.emit) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.emit) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== design/cpa_datapath.sv =====
// ============================================================================
// cpa_datapath
// Configuration registers, PI2 state, shared multiplier, fold divider by 127,
// radix-2 divider for the cap and the packet decision logic of the coupled
// PI2 AQM unit.
// ============================================================================
module cpa_datapath import cpa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_opcode,
    input  logic [PROB_W-1:0]    s_delay_classic_ns,
    input  logic [PROB_W-1:0]    s_delay_l4s_ns,
    input  logic                 s_is_l4s,
    input  logic                 s_ect_capable,
    input  logic [PROB_W-1:0]    s_backlog_bytes,
    input  logic [PROB_W-1:0]    s_rand_a,
    input  logic [PROB_W-1:0]    s_rand_b,
    output logic [1:0]           m_verdict,
    output logic [PROB_W-1:0]    m_probability,
    input  dp_cmd_t              cmd,
    output dp_status_t           status
);

    // configuration
    logic [PROB_W-1:0] target_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [K_W-1:0]    k_reg;
    logic              doo_reg;
    logic [MTU_W-1:0]  mtu_reg;

    // state
    logic [PROB_W-1:0] prob_reg;
    logic [PROB_W-1:0] prev_reg;

    // latched beat
    logic              op_reg;
    logic [PROB_W-1:0] dc_reg, dl_reg, backlog_reg, ra_reg, rb_reg;
    logic              l4s_reg, ect_reg;

    // working registers
    logic [ACC_W-1:0]  acc_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [K_W-1:0]    rem_reg;
    logic [K_W-1:0]    divisor_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [TERM_W-1:0] t1_reg, t2_reg;
    logic [PROB_W-1:0] pnew_reg;
    verdict_t          verdict_reg;
    logic [1:0]        m_verdict_reg;
    logic [PROB_W-1:0] m_prob_reg;

    // combinational
    logic [PROB_W-1:0] q_max;
    logic [PROB_W:0]   diff;
    logic              diff_neg;
    logic [PROB_W-1:0] diff_mag;
    logic [PROB_W-1:0] mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [ACC_W-1:0]  product;
    logic [ACC_W-1:0]  fold;
    logic              fold_hit;
    logic [K_W:0]      trial;
    logic              trial_ge;
    logic [K_W-1:0]    rem_new;
    logic [TERM_W-1:0] term;
    logic [SUM_W-1:0]  sum;
    logic [PROB_W-1:0] clamped;
    logic [K_W-1:0]    k_nz;
    logic [PROB_W-1:0] cap;
    logic              small_backlog;
    logic              overloaded;
    logic              sq_hit;
    verdict_t          pkt_verdict;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= PROB_W'(15000000);
            ki_reg     <= GAIN_W'(44);
            kp_reg     <= GAIN_W'(879);
            k_reg      <= K_W'(2);
            doo_reg    <= 1'b1;
            mtu_reg    <= MTU_W'(1514);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TARGET_DELAY: target_reg <= cfg_wdata[PROB_W-1:0];
                CFG_INT_GAIN:     ki_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_PROP_GAIN:    kp_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_COUPLING_K:   k_reg      <= cfg_wdata[K_W-1:0];
                CFG_DROP_OVLD:    doo_reg    <= cfg_wdata[0];
                CFG_MTU:          mtu_reg    <= cfg_wdata[MTU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        q_max = (dc_reg > dl_reg) ? dc_reg : dl_reg;
        if (cmd.op == OP_TERM2) begin
            diff  = {1'b0, q_max} - {1'b0, prev_reg};
            mul_b = kp_reg;
        end else begin
            diff  = {1'b0, q_max} - {1'b0, target_reg};
            mul_b = ki_reg;
        end
        diff_neg = diff[PROB_W];
        diff_mag = diff_neg ? PROB_W'((PROB_W+1)'(0) - diff) : diff[PROB_W-1:0];
        if (cmd.op == OP_PKT_MUL) begin
            mul_a = prob_reg;
            mul_b = GAIN_W'(k_reg);
        end else begin
            mul_a = diff_mag;
        end
        product = ACC_W'(mul_a) * ACC_W'(mul_b);

        // r = 128a + b keeps its residue as a + b, the quotient grows by a
        fold     = ACC_W'(acc_reg[ACC_W-1:GAIN_SHIFT]) + ACC_W'(acc_reg[GAIN_SHIFT-1:0]);
        fold_hit = acc_reg == ACC_W'(GAIN_DIVISOR);

        trial    = {rem_reg, acc_reg[ACC_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};
        rem_new  = trial_ge ? K_W'(trial - {1'b0, divisor_reg}) : trial[K_W-1:0];

        term = neg_reg ? (TERM_W'(0) - {1'b0, quo_reg}) : {1'b0, quo_reg};

        sum = SUM_W'(prob_reg) + {{(SUM_W-TERM_W){t1_reg[TERM_W-1]}}, t1_reg}
                               + {{(SUM_W-TERM_W){t2_reg[TERM_W-1]}}, t2_reg};
        if (sum[SUM_W-1]) clamped = '0;
        else if (sum[SUM_W-2:PROB_W] != '0) clamped = PROB_MAX;
        else clamped = sum[PROB_W-1:0];

        k_nz = (k_reg == '0) ? K_W'(1) : k_reg;
        cap  = acc_reg[PROB_W-1:0];

        small_backlog = {1'b0, backlog_reg} < (PROB_W+1)'({mtu_reg, 1'b0});
        overloaded    = acc_reg[PROB_W+K_W-1:PROB_W] != '0;
        sq_hit        = (ra_reg <= prob_reg) && (rb_reg <= prob_reg);
        if (small_backlog) begin
            pkt_verdict = VERDICT_PASS;
        end else if (l4s_reg) begin
            if (overloaded) pkt_verdict = (doo_reg && sq_hit) ? VERDICT_DROP : VERDICT_MARK;
            else if ((PROB_W+K_W)'(ra_reg) <= acc_reg[PROB_W+K_W-1:0])
                pkt_verdict = VERDICT_MARK;
            else pkt_verdict = VERDICT_PASS;
        end else if (sq_hit) begin
            pkt_verdict = (ect_reg && !overloaded) ? VERDICT_MARK : VERDICT_DROP;
        end else begin
            pkt_verdict = VERDICT_PASS;
        end
    end

    // input beat capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_opcode;
            dc_reg      <= s_delay_classic_ns;
            dl_reg      <= s_delay_l4s_ns;
            l4s_reg     <= s_is_l4s;
            ect_reg     <= s_ect_capable;
            backlog_reg <= s_backlog_bytes;
            ra_reg      <= s_rand_a;
            rb_reg      <= s_rand_b;
        end
    end

    // multiplier, divider and sum registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_TERM1, OP_TERM2: begin
                acc_reg <= product;
                neg_reg <= diff_neg;
                quo_reg <= '0;
                cnt_reg <= FOLD_STEPS;
            end
            OP_PKT_MUL: acc_reg <= product;
            OP_FOLD: begin
                if (fold_hit) begin
                    acc_reg <= '0;
                    quo_reg <= quo_reg + QUO_W'(1);
                end else begin
                    acc_reg <= fold;
                    quo_reg <= quo_reg + QUO_W'(acc_reg[ACC_W-1:GAIN_SHIFT]);
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_DIV_STEP: begin
                acc_reg <= {acc_reg[ACC_W-2:0], trial_ge};
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_SAVE1: t1_reg <= term;
            OP_SAVE2: t2_reg <= term;
            OP_SUM:   pnew_reg <= clamped;
            OP_CAP_LOAD: begin
                acc_reg     <= ACC_W'(PROB_MAX);
                rem_reg     <= '0;
                divisor_reg <= k_nz;
                cnt_reg     <= DIV_STEPS;
            end
            OP_CAP_SAVE: if (pnew_reg > cap) pnew_reg <= cap;
            OP_PKT_DEC:  verdict_reg <= pkt_verdict;
            OP_COMMIT:   verdict_reg <= VERDICT_PASS;
            OP_NONE: ;
            default: ;
        endcase
    end

    // pi2 state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prob_reg <= '0;
            prev_reg <= '0;
        end else if (cmd.op == OP_COMMIT) begin
            prob_reg <= pnew_reg;
            prev_reg <= q_max;
        end
    end

    // output beat
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_verdict_reg <= verdict_reg;
            m_prob_reg    <= prob_reg;
        end
    end

    assign m_verdict     = m_verdict_reg;
    assign m_probability = m_prob_reg;

    assign status.is_tick          = !op_reg;
    assign status.div_last         = cnt_reg == CNT_W'(1);
    assign status.drop_on_overload = doo_reg;

endmodule

// ===== dv/coupled_pi2_aqm_unit_test.sv =====
// ============================================================================
// coupled_pi2_aqm_unit_test
// Self-checking bench for the coupled PI2 AQM unit. Tick and packet beats go
// in through a randomly stalled valid/ready channel. A behavioral model of
// the PI2 probability update and of the coupled pass/mark/drop rules
// predicts every result beat, and the monitor checks them in order.
// ============================================================================
module coupled_pi2_aqm_unit_test;
    import cpa_pkg::*;

    localparam logic OPC_TICK   = 1'b0;
    localparam logic OPC_PACKET = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int SINK_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int TAIL_CYCLES      = 200;
    localparam int PHASE_BEATS      = 104;

    typedef struct {
        logic              opcode;
        logic [PROB_W-1:0] delay_classic;
        logic [PROB_W-1:0] delay_l4s;
        logic              is_l4s;
        logic              ect;
        logic [PROB_W-1:0] backlog;
        logic [PROB_W-1:0] rand_a;
        logic [PROB_W-1:0] rand_b;
    } aqm_beat_t;

    typedef struct {
        verdict_t          verdict;
        logic [PROB_W-1:0] probability;
    } aqm_result_t;

    logic                 aclk               = 1'b0;
    logic                 aresetn            = 1'b0;
    logic                 cfg_wr_en          = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index          = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata          = '0;
    logic                 s_valid            = 1'b0;
    logic                 s_ready;
    logic                 s_opcode           = 1'b0;
    logic [PROB_W-1:0]    s_delay_classic_ns = '0;
    logic [PROB_W-1:0]    s_delay_l4s_ns     = '0;
    logic                 s_is_l4s           = 1'b0;
    logic                 s_ect_capable      = 1'b0;
    logic [PROB_W-1:0]    s_backlog_bytes    = '0;
    logic [PROB_W-1:0]    s_rand_a           = '0;
    logic [PROB_W-1:0]    s_rand_b           = '0;
    logic                 m_valid;
    logic                 m_ready            = 1'b0;
    logic [1:0]           m_verdict;
    logic [PROB_W-1:0]    m_probability;

    coupled_pi2_aqm_unit u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_delay_classic_ns (s_delay_classic_ns),
        .s_delay_l4s_ns     (s_delay_l4s_ns),
        .s_is_l4s           (s_is_l4s),
        .s_ect_capable      (s_ect_capable),
        .s_backlog_bytes    (s_backlog_bytes),
        .s_rand_a           (s_rand_a),
        .s_rand_b           (s_rand_b),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_verdict          (m_verdict),
        .m_probability      (m_probability)
    );

    always #1 aclk = ~aclk;

    // shadow registers and controller state
    logic [PROB_W-1:0] model_target     = 32'd15000000;
    logic [GAIN_W-1:0] model_igain      = 18'd44;
    logic [GAIN_W-1:0] model_pgain      = 18'd879;
    logic [K_W-1:0]    model_k          = 8'd2;
    logic              model_drop       = 1'b1;
    logic [MTU_W-1:0]  model_mtu        = 16'd1514;
    logic [PROB_W-1:0] model_prob       = '0;
    logic [PROB_W-1:0] model_prev_delay = '0;

    aqm_beat_t   queued_beats[$];
    aqm_result_t predicted_results[$];

    int beats_queued   = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int src_idle_pct   = 33;
    int sink_idle_pct  = 56;
    int sink_hold_reqs = 0;
    int sink_hold_seen = 0;
    int sink_hold_left = 0;
    int quiet_cycles   = 0;
    int settings_used  = 1;
    int tick_count     = 0;
    int packet_count   = 0;
    int overload_count = 0;
    int pinned_low     = 0;
    int pinned_high    = 0;
    int verdict_hits[3];

    function automatic aqm_result_t predict_beat(aqm_beat_t b);
        aqm_result_t       r;
        longint            q;
        longint            total;
        logic [PROB_W-1:0] cap;
        logic [63:0]       p64;
        logic [63:0]       lp64;
        logic [63:0]       floor64;
        logic              overloaded;
        logic              both_rolls;
        r.verdict = VERDICT_PASS;
        if (b.opcode == OPC_TICK) begin
            tick_count++;
            q = {32'd0, (b.delay_classic > b.delay_l4s) ? b.delay_classic : b.delay_l4s};
            total = longint'({32'd0, model_prob})
                  + ((q - longint'({32'd0, model_target})) * longint'({46'd0, model_igain})) / 127
                  + ((q - longint'({32'd0, model_prev_delay})) * longint'({46'd0, model_pgain}))
                    / 127;
            if (total < 0) begin
                model_prob = '0;
                pinned_low++;
            end else if (total > longint'({32'd0, PROB_MAX})) begin
                model_prob = PROB_MAX;
                pinned_high++;
            end else begin
                model_prob = total[PROB_W-1:0];
            end
            if (!model_drop) begin
                cap = (model_k == '0) ? PROB_MAX : PROB_MAX / PROB_W'(model_k);
                if (model_prob > cap) model_prob = cap;
            end
            model_prev_delay = q[PROB_W-1:0];
        end else begin
            packet_count++;
            p64        = {32'd0, model_prob};
            lp64       = p64 * {56'd0, model_k};
            floor64    = {47'd0, model_mtu, 1'b0};
            overloaded = lp64 > {32'd0, PROB_MAX};
            both_rolls = ({32'd0, b.rand_a} <= p64) && ({32'd0, b.rand_b} <= p64);
            if ({32'd0, b.backlog} < floor64) begin
                r.verdict = VERDICT_PASS;
            end else begin
                if (overloaded) overload_count++;
                if (b.is_l4s) begin
                    if (overloaded) begin
                        r.verdict = (model_drop && both_rolls) ? VERDICT_DROP : VERDICT_MARK;
                    end else if ({32'd0, b.rand_a} <= lp64) begin
                        r.verdict = VERDICT_MARK;
                    end
                end else if (both_rolls) begin
                    r.verdict = (b.ect && !overloaded) ? VERDICT_MARK : VERDICT_DROP;
                end
            end
        end
        r.probability = model_prob;
        verdict_hits[r.verdict]++;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [PROB_W-1:0] want, logic [PROB_W-1:0] got);
        mismatches++;
        $display("mismatch at result beat %0d: %s expected %0h got %0h",
                 results_seen, what, want, got);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_TARGET_DELAY: model_target = data;
            CFG_INT_GAIN:     model_igain  = data[GAIN_W-1:0];
            CFG_PROP_GAIN:    model_pgain  = data[GAIN_W-1:0];
            CFG_COUPLING_K:   model_k      = data[K_W-1:0];
            CFG_DROP_OVLD:    model_drop   = data[0];
            CFG_MTU:          model_mtu    = data[MTU_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic push_beat(aqm_beat_t b);
        queued_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen != beats_queued) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic aqm_beat_t noise_beat();
        aqm_beat_t b;
        b.opcode        = 1'($urandom_range(1));
        b.delay_classic = $urandom();
        b.delay_l4s     = $urandom();
        b.is_l4s        = 1'($urandom_range(1));
        b.ect           = 1'($urandom_range(1));
        b.backlog       = $urandom();
        b.rand_a        = $urandom();
        b.rand_b        = $urandom();
        return b;
    endfunction

    function automatic aqm_beat_t tick_beat(logic [PROB_W-1:0] dc, logic [PROB_W-1:0] dl);
        aqm_beat_t b;
        b               = noise_beat();
        b.opcode        = OPC_TICK;
        b.delay_classic = dc;
        b.delay_l4s     = dl;
        return b;
    endfunction

    function automatic aqm_beat_t packet_beat(logic l4s, logic ect, logic [PROB_W-1:0] backlog,
                                              logic [PROB_W-1:0] ra, logic [PROB_W-1:0] rb);
        aqm_beat_t b;
        b         = noise_beat();
        b.opcode  = OPC_PACKET;
        b.is_l4s  = l4s;
        b.ect     = ect;
        b.backlog = backlog;
        b.rand_a  = ra;
        b.rand_b  = rb;
        return b;
    endfunction

    // mostly near the target, sometimes far off or at the rails
    function automatic logic [PROB_W-1:0] delay_word();
        logic [PROB_W-1:0] offset;
        longint            v;
        offset = $urandom();
        offset = offset >> $urandom_range(4, 31);
        case ($urandom_range(9))
            0: return '0;
            1: return PROB_MAX;
            2, 3: return $urandom();
            default: begin
                v = longint'({32'd0, model_target});
                if ($urandom_range(1) == 1) v = v + longint'({32'd0, offset});
                else v = v - longint'({32'd0, offset});
                if (v < 0) v = 0;
                if (v > longint'({32'd0, PROB_MAX})) v = longint'({32'd0, PROB_MAX});
                return v[PROB_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [PROB_W-1:0] roll_word();
        logic [PROB_W-1:0] w;
        w = $urandom();
        case ($urandom_range(7))
            0: return '0;
            1: return PROB_MAX;
            2, 3: return w;
            default: return w >> $urandom_range(0, 8);
        endcase
    endfunction

    function automatic logic [PROB_W-1:0] backlog_word();
        logic [PROB_W-1:0] floor_b;
        logic [PROB_W-1:0] w;
        floor_b = {15'd0, model_mtu, 1'b0};
        w = $urandom();
        case ($urandom_range(19))
            0, 1: return (floor_b == '0) ? '0 : $urandom_range(0, floor_b - 1);
            2: return (floor_b == '0) ? '0 : floor_b - 1;
            3: return floor_b;
            4: return PROB_MAX;
            5, 6: return w;
            default: return floor_b + (w >> $urandom_range(12, 31));
        endcase
    endfunction

    task automatic queue_random(int n);
        aqm_beat_t b;
        for (int i = 0; i < n; i++) begin
            b = noise_beat();
            if ($urandom_range(99) < 30) begin
                b.opcode        = OPC_TICK;
                b.delay_classic = delay_word();
                case ($urandom_range(2))
                    0: b.delay_l4s = delay_word();
                    1: b.delay_l4s = b.delay_classic;
                    default: b.delay_l4s = '0;
                endcase
            end else begin
                b.opcode  = OPC_PACKET;
                b.backlog = backlog_word();
                b.rand_a  = roll_word();
                b.rand_b  = roll_word();
            end
            push_beat(b);
        end
    endtask

    task automatic apply_setting(int phase);
        case (phase)
            0: begin
                write_reg(CFG_TARGET_DELAY, 32'd15000000);
                write_reg(CFG_INT_GAIN, 32'd44);
                write_reg(CFG_PROP_GAIN, 32'd879);
                write_reg(CFG_COUPLING_K, 32'd2);
                write_reg(CFG_DROP_OVLD, 32'd1);
                write_reg(CFG_MTU, 32'd1514);
            end
            1, 6: begin
                write_reg(CFG_TARGET_DELAY, $urandom_range(0, 1 << 27));
                write_reg(CFG_INT_GAIN, $urandom_range(0, 171798));
                write_reg(CFG_PROP_GAIN, $urandom_range(0, 171798));
                write_reg(CFG_COUPLING_K, $urandom_range(1, 255));
                write_reg(CFG_DROP_OVLD, 32'd0);
                write_reg(CFG_MTU, $urandom_range(64, 9000));
            end
            2: begin
                write_reg(CFG_TARGET_DELAY, '0);
                write_reg(CFG_INT_GAIN, 32'h3FFFF);
                write_reg(CFG_PROP_GAIN, 32'h3FFFF);
                write_reg(CFG_COUPLING_K, 32'd255);
                write_reg(CFG_DROP_OVLD, 32'd1);
                write_reg(CFG_MTU, 32'd64);
            end
            4: begin
                write_reg(CFG_TARGET_DELAY, PROB_MAX);
                write_reg(CFG_INT_GAIN, '0);
                write_reg(CFG_PROP_GAIN, $urandom_range(1, 171798));
                write_reg(CFG_COUPLING_K, 32'd1);
                write_reg(CFG_DROP_OVLD, 32'd0);
                write_reg(CFG_MTU, 32'd65535);
            end
            5: begin
                // upper data bits beyond each register width are don't-care
                write_reg(CFG_TARGET_DELAY, $urandom());
                write_reg(CFG_INT_GAIN, $urandom());
                write_reg(CFG_PROP_GAIN, $urandom());
                write_reg(CFG_COUPLING_K, {24'($urandom_range(0, 32'hFF_FFFF)), 8'd0});
                write_reg(CFG_DROP_OVLD, $urandom());
                write_reg(CFG_MTU, $urandom());
            end
            default: begin
                write_reg(CFG_TARGET_DELAY, $urandom_range(0, 1 << 30));
                write_reg(CFG_INT_GAIN, $urandom_range(0, 171798));
                write_reg(CFG_PROP_GAIN, $urandom_range(0, 171798));
                write_reg(CFG_COUPLING_K, $urandom_range(1, 255));
                write_reg(CFG_DROP_OVLD, $urandom_range(1));
                write_reg(CFG_MTU, $urandom_range(64, 65535));
            end
        endcase
        end_writes();
    endtask

    always @(posedge aclk) begin : drive_beats
        aqm_beat_t nxt;
        aqm_beat_t seen;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seen.opcode        = s_opcode;
                seen.delay_classic = s_delay_classic_ns;
                seen.delay_l4s     = s_delay_l4s_ns;
                seen.is_l4s        = s_is_l4s;
                seen.ect           = s_ect_capable;
                seen.backlog       = s_backlog_bytes;
                seen.rand_a        = s_rand_a;
                seen.rand_b        = s_rand_b;
                predicted_results.push_back(predict_beat(seen));
            end
            if (!s_valid || s_ready) begin
                if (queued_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt                = queued_beats.pop_front();
                    s_valid            <= 1'b1;
                    s_opcode           <= nxt.opcode;
                    s_delay_classic_ns <= nxt.delay_classic;
                    s_delay_l4s_ns     <= nxt.delay_l4s;
                    s_is_l4s           <= nxt.is_l4s;
                    s_ect_capable      <= nxt.ect;
                    s_backlog_bytes    <= nxt.backlog;
                    s_rand_a           <= nxt.rand_a;
                    s_rand_b           <= nxt.rand_b;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        aqm_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    report_mismatch("result beat with none outstanding", '0, m_probability);
                end else begin
                    want = predicted_results.pop_front();
                    if (m_verdict !== want.verdict)
                        report_mismatch("verdict", want.verdict, m_verdict);
                    if (m_probability !== want.probability)
                        report_mismatch("probability", want.probability, m_probability);
                end
            end
            if (sink_hold_seen != sink_hold_reqs) begin
                sink_hold_seen = sink_hold_reqs;
                sink_hold_left = SINK_HOLD_CYCLES;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a beat", quiet_cycles);
            $display("** coupled_pi2_aqm_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, probability still zero
        push_beat(packet_beat(1'b1, 1'b0, '0, '0, '0));
        push_beat(packet_beat(1'b1, 1'b1, 32'd3027, '0, '0));
        push_beat(packet_beat(1'b1, 1'b0, 32'd3028, '0, PROB_MAX));
        push_beat(packet_beat(1'b0, 1'b1, PROB_MAX, '0, '0));
        push_beat(packet_beat(1'b0, 1'b0, PROB_MAX, '0, '0));
        push_beat(packet_beat(1'b0, 1'b1, PROB_MAX, '0, 32'd1));
        // integral term just below target truncates toward zero
        push_beat(tick_beat('0, 32'd14999999));
        push_beat(tick_beat(PROB_MAX, PROB_MAX));
        push_beat(packet_beat(1'b1, 1'b1, PROB_MAX, PROB_MAX, PROB_MAX));
        push_beat(packet_beat(1'b0, 1'b1, PROB_MAX, 32'h8000_0000, '0));
        push_beat(tick_beat('0, '0));
        wait_drained();

        // probability cap without overload drops
        write_reg(CFG_COUPLING_K, 32'd3);
        write_reg(CFG_DROP_OVLD, 32'd0);
        end_writes();
        push_beat(tick_beat(PROB_MAX, '0));
        push_beat(packet_beat(1'b1, 1'b0, PROB_MAX, PROB_MAX, '0));
        wait_drained();

        // coupling raised past the cap: overloaded
        write_reg(CFG_COUPLING_K, 32'd4);
        end_writes();
        push_beat(packet_beat(1'b1, 1'b1, PROB_MAX, PROB_MAX, PROB_MAX));
        push_beat(packet_beat(1'b0, 1'b0, PROB_MAX, '0, '0));
        push_beat(packet_beat(1'b0, 1'b1, PROB_MAX, '0, '0));
        wait_drained();

        // zero coupling, unused register slots, mtu of 64
        write_reg(CFG_COUPLING_K, '0);
        write_reg(CFG_SPARE_LO, $urandom());
        write_reg(CFG_SPARE_HI, $urandom());
        write_reg(CFG_MTU, 32'd64);
        end_writes();
        push_beat(tick_beat(32'd15000000, 32'd15000000));
        push_beat(packet_beat(1'b1, 1'b0, 32'd128, '0, PROB_MAX));
        push_beat(packet_beat(1'b1, 1'b0, 32'd127, '0, '0));
        push_beat(packet_beat(1'b1, 1'b1, 32'd128, 32'd1, '0));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                src_idle_pct  = 56;
                sink_idle_pct = 33;
            end
            if (ph == 6) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            apply_setting(ph);
            queue_random(PHASE_BEATS);
            // long receiver stall while the sender keeps offering
            if (ph == 1 || ph == 6) sink_hold_reqs++;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (predicted_results.size() != 0)
            report_mismatch("result beats never returned", '0, predicted_results.size());

        $display("covered %0d tick and %0d packet beats over %0d register settings",
                 tick_count, packet_count, settings_used);
        $display("verdicts pass/mark/drop %0d/%0d/%0d, %0d overloaded, p pinned low %0d high %0d",
                 verdict_hits[VERDICT_PASS], verdict_hits[VERDICT_MARK],
                 verdict_hits[VERDICT_DROP], overload_count, pinned_low, pinned_high);
        if (mismatches == 0) begin
            $display("** coupled_pi2_aqm_unit: PASSED **");
        end else begin
            $display("** coupled_pi2_aqm_unit: FAILED **");
        end
        $finish;
    end

endmodule
